/* rtl/core/rdmc_pkg.sv */
// Shared types and constants of the randomized depth-first maze carver.
package rdmc_pkg;

  // Default grid bounds of the cell store.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0]  CFG_WIDTH_IDX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_HEIGHT_IDX = 1'd1;
  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RST   = 7'd64;

  // Request modes.
  localparam logic [1:0] MODE_STEP    = 2'd0;
  localparam logic [1:0] MODE_RESTART = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Carve directions, also the neighbor scan order.
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Cell bits: bit 0 visited, bit 1 right wall, bit 2 bottom wall.
  localparam int BIT_VIS    = 0;
  localparam int BIT_RIGHT  = 1;
  localparam int BIT_BOTTOM = 2;
  localparam logic [2:0] MASK_VIS    = 3'b001;
  localparam logic [2:0] MASK_RIGHT  = 3'b010;
  localparam logic [2:0] MASK_BOTTOM = 3'b100;
  localparam logic [2:0] CELL_WALLS  = 3'b110;
  localparam logic [2:0] CELL_ORIGIN = 3'b111;

  // Scan counter: probe 0 is the popped cell, probes 1..4 its neighbors.
  localparam logic [2:0] SCAN_LAST = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDCELL,
    ST_POP,
    ST_SCAN,
    ST_PICK,
    ST_CARVE,
    ST_PUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] random_fraction;
    logic [5:0]  read_x;
    logic [5:0]  read_y;
  } in_item_t;

  typedef struct packed {
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       carved;
    logic [1:0] direction;
    logic       east_wall;
    logic       south_wall;
    logic       visited_flag;
    logic       finished;
  } out_item_t;

endpackage

/* rtl/core/rdmc_chan_if.sv */
// Valid/ready channel carrying one request or result payload.
interface rdmc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/rdmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/random_dfs_maze_carver_top.sv */
// Randomized depth-first maze carver: sequencer, cell store and coordinate stack.
//
// The block carves a maze over a MAX_WIDTH x MAX_HEIGHT cell store by
// randomized depth-first search, one request at a time. A step request pops
// the top of the coordinate stack, probes the popped cell and its four
// neighbors one per cycle through the single read port of the cell RAM,
// picks one unvisited neighbor with a 16 x 3 multiply of random_fraction by
// the neighbor count, then clears the shared wall and pushes both cells in
// the CARVE and PUSH states. The cell RAM read port sets the step length. A
// restart request runs a clearing pass that writes every cell of the store,
// one per cycle; the same pass runs right after reset, with no result, and
// in_chan.ready stays low throughout it. The block takes no new request
// while one is in flight. A finished result waits in the output register
// without blocking the next accept; that next request then holds in its last
// cycle until the register frees. Write the size registers only while the
// block is idle.
module random_dfs_maze_carver_top #(
  parameter int MAX_WIDTH  = rdmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rdmc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rdmc_chan_if.sink                       in_chan,
  rdmc_chan_if.source                     out_chan,
  input  logic                            cfg_we,
  input  logic [rdmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int SW    = XW + YW;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);

  // Row-major cell address: y * MAX_WIDTH + x.
  function automatic logic [AW-1:0] cell_addr(input logic [8:0] x, input logic [8:0] y);
    logic [31:0] full;
    full = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
    return full[AW-1:0];
  endfunction

  // Size registers and their clamped values.
  logic [rdmc_pkg::CFG_DATA_W-1:0] width_r, height_r;
  logic [8:0] w_eff, h_eff;

  // Sequencer and stack control.
  rdmc_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_reply_r;
  logic [DW-1:0] depth_r;
  logic [2:0]    k_r;

  // Step datapath.
  logic [XW-1:0] cx_r;
  logic [YW-1:0] cy_r;
  logic [2:0]    cur_bits_r;
  logic [2:0]    nbr_bits_r [4];
  logic [15:0]   frac_r;
  logic [1:0]    dir_r;
  logic          rd_ok_r;

  // Result staging and output register.
  rdmc_pkg::out_item_t res_r;
  rdmc_pkg::out_item_t res_start, res_final;
  rdmc_pkg::out_item_t out_data_r;
  logic                out_valid_r;

  // RAM ports.
  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [2:0]    cell_wdata, cell_rdata;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  // Combinational helpers.
  logic          in_fire, out_fire, out_free;
  logic [DW-1:0] depth_m1;
  logic          stk_room;
  logic [XW-1:0] probe_x, nx;
  logic [YW-1:0] probe_y, ny;
  logic [3:0]    avail;
  logic [2:0]    nbr_count;
  logic [18:0]   pick_prod;
  logic [1:0]    pick, pick_dir, seen;
  logic          found;
  logic [2:0]    nb_bits;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign depth_m1 = depth_r - DW'(1);
  assign stk_room = depth_r < DW'(CELLS);

  assign in_chan.ready    = (state_r == rdmc_pkg::ST_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  // Clamp the size registers: zero acts as one, anything above the store as its bound.
  always_comb begin
    if (width_r == '0) begin
      w_eff = 9'd1;
    end else if (9'(width_r) > 9'(MAX_WIDTH)) begin
      w_eff = 9'(MAX_WIDTH);
    end else begin
      w_eff = 9'(width_r);
    end
    if (height_r == '0) begin
      h_eff = 9'd1;
    end else if (9'(height_r) > 9'(MAX_HEIGHT)) begin
      h_eff = 9'(MAX_HEIGHT);
    end else begin
      h_eff = 9'(height_r);
    end
  end

  // Probe coordinates for the scan: the popped cell, then left, right, up, down.
  always_comb begin
    probe_x = cx_r;
    probe_y = cy_r;
    case (k_r)
      3'd1:    probe_x = cx_r - XW'(1);
      3'd2:    probe_x = cx_r + XW'(1);
      3'd3:    probe_y = cy_r - YW'(1);
      3'd4:    probe_y = cy_r + YW'(1);
      default: ;
    endcase
  end

  // Unvisited neighbors inside the grid in use; out-of-grid probes are masked here.
  always_comb begin
    avail[0] = (cx_r != '0) && !nbr_bits_r[0][rdmc_pkg::BIT_VIS];
    avail[1] = ((9'(cx_r) + 9'd1) < w_eff) && !nbr_bits_r[1][rdmc_pkg::BIT_VIS];
    avail[2] = (cy_r != '0) && !nbr_bits_r[2][rdmc_pkg::BIT_VIS];
    avail[3] = ((9'(cy_r) + 9'd1) < h_eff) && !nbr_bits_r[3][rdmc_pkg::BIT_VIS];
    nbr_count = {2'b0, avail[0]} + {2'b0, avail[1]} + {2'b0, avail[2]} + {2'b0, avail[3]};
  end

  // Neighbor pick: pick = floor(fraction * count / 65536), then select the
  // pick-th available neighbor in scan order.
  always_comb begin
    pick_prod = {3'b0, frac_r} * {16'b0, nbr_count};
    pick      = pick_prod[17:16];
    pick_dir  = rdmc_pkg::DIR_LEFT;
    seen      = 2'd0;
    found     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (avail[i]) begin
        if (!found && seen == pick) begin
          pick_dir = 2'(i);
          found    = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

  // Chosen neighbor coordinates and its stored bits.
  always_comb begin
    nx = cx_r;
    ny = cy_r;
    unique case (dir_r)
      rdmc_pkg::DIR_LEFT:  nx = cx_r - XW'(1);
      rdmc_pkg::DIR_RIGHT: nx = cx_r + XW'(1);
      rdmc_pkg::DIR_UP:    ny = cy_r - YW'(1);
      rdmc_pkg::DIR_DOWN:  ny = cy_r + YW'(1);
    endcase
    nb_bits = nbr_bits_r[dir_r];
  end

  // Result fields known at accept time, and the result as it leaves.
  always_comb begin
    res_start = '0;
    if (in_chan.payload.mode == rdmc_pkg::MODE_READ) begin
      res_start.cell_x = in_chan.payload.read_x;
      res_start.cell_y = in_chan.payload.read_y;
    end
    res_final          = res_r;
    res_final.finished = (depth_r == '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdmc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(CELLS - 1)) begin
          state_nxt = clr_reply_r ? rdmc_pkg::ST_DONE : rdmc_pkg::ST_IDLE;
        end
      end
      rdmc_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.payload.mode)
            rdmc_pkg::MODE_STEP: begin
              state_nxt = (depth_r != '0) ? rdmc_pkg::ST_POP : rdmc_pkg::ST_DONE;
            end
            rdmc_pkg::MODE_RESTART: state_nxt = rdmc_pkg::ST_CLEAR;
            rdmc_pkg::MODE_READ:    state_nxt = rdmc_pkg::ST_RDCELL;
            default:                state_nxt = rdmc_pkg::ST_DONE;
          endcase
        end
      end
      rdmc_pkg::ST_RDCELL: state_nxt = rdmc_pkg::ST_DONE;
      rdmc_pkg::ST_POP:    state_nxt = rdmc_pkg::ST_SCAN;
      rdmc_pkg::ST_SCAN: begin
        if (k_r == rdmc_pkg::SCAN_LAST) begin
          state_nxt = rdmc_pkg::ST_PICK;
        end
      end
      rdmc_pkg::ST_PICK: begin
        state_nxt = (nbr_count == 3'd0) ? rdmc_pkg::ST_DONE : rdmc_pkg::ST_CARVE;
      end
      rdmc_pkg::ST_CARVE: state_nxt = rdmc_pkg::ST_PUSH;
      rdmc_pkg::ST_PUSH:  state_nxt = rdmc_pkg::ST_DONE;
      rdmc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = rdmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rdmc_pkg::ST_IDLE;
    endcase
  end

  // RAM port control per state.
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cell_addr(9'(cx_r), 9'(cy_r));
    cell_wdata = rdmc_pkg::CELL_WALLS;
    cell_raddr = cell_addr(9'(probe_x), 9'(probe_y));
    stk_we     = 1'b0;
    stk_waddr  = depth_r[AW-1:0];
    stk_wdata  = {cy_r, cx_r};
    stk_raddr  = depth_m1[AW-1:0];
    unique case (state_r)
      rdmc_pkg::ST_CLEAR: begin
        // Sweep the store; keep the origin entry on the stack.
        cell_we    = 1'b1;
        cell_waddr = clr_cnt_r;
        cell_wdata = (clr_cnt_r == '0) ? rdmc_pkg::CELL_ORIGIN : rdmc_pkg::CELL_WALLS;
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = '0;
      end
      rdmc_pkg::ST_IDLE: begin
        cell_raddr = cell_addr(9'(in_chan.payload.read_x), 9'(in_chan.payload.read_y));
      end
      rdmc_pkg::ST_CARVE: begin
        // Clear the shared wall; it lives in whichever cell is left of or above the other.
        cell_we = 1'b1;
        unique case (dir_r)
          rdmc_pkg::DIR_RIGHT: begin
            cell_wdata = cur_bits_r & ~rdmc_pkg::MASK_RIGHT;
          end
          rdmc_pkg::DIR_DOWN: begin
            cell_wdata = cur_bits_r & ~rdmc_pkg::MASK_BOTTOM;
          end
          rdmc_pkg::DIR_LEFT: begin
            cell_waddr = cell_addr(9'(nx), 9'(ny));
            cell_wdata = (nb_bits & ~rdmc_pkg::MASK_RIGHT) | rdmc_pkg::MASK_VIS;
          end
          rdmc_pkg::DIR_UP: begin
            cell_waddr = cell_addr(9'(nx), 9'(ny));
            cell_wdata = (nb_bits & ~rdmc_pkg::MASK_BOTTOM) | rdmc_pkg::MASK_VIS;
          end
        endcase
        stk_we = stk_room;
      end
      rdmc_pkg::ST_PUSH: begin
        // Mark the neighbor visited when the wall sat in the popped cell.
        cell_we    = (dir_r == rdmc_pkg::DIR_RIGHT) || (dir_r == rdmc_pkg::DIR_DOWN);
        cell_waddr = cell_addr(9'(nx), 9'(ny));
        cell_wdata = nb_bits | rdmc_pkg::MASK_VIS;
        stk_we     = stk_room;
        stk_wdata  = {ny, nx};
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdmc_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      depth_r     <= DW'(1);
      k_r         <= '0;
      out_valid_r <= 1'b0;
      width_r     <= rdmc_pkg::CFG_SIZE_RST;
      height_r    <= rdmc_pkg::CFG_SIZE_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          rdmc_pkg::CFG_WIDTH_IDX:  width_r  <= cfg_wdata;
          rdmc_pkg::CFG_HEIGHT_IDX: height_r <= cfg_wdata;
        endcase
      end

      if (state_r == rdmc_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        depth_r   <= DW'(1);
      end else begin
        clr_cnt_r <= '0;
      end

      if (in_fire) begin
        clr_reply_r <= (in_chan.payload.mode == rdmc_pkg::MODE_RESTART);
        if (in_chan.payload.mode == rdmc_pkg::MODE_STEP && depth_r != '0) begin
          depth_r <= depth_m1;
        end
      end

      if ((state_r == rdmc_pkg::ST_CARVE || state_r == rdmc_pkg::ST_PUSH) && stk_room) begin
        depth_r <= depth_r + DW'(1);
      end

      if (state_r == rdmc_pkg::ST_SCAN) begin
        k_r <= k_r + 3'd1;
      end else begin
        k_r <= '0;
      end

      if (state_r == rdmc_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      frac_r  <= in_chan.payload.random_fraction;
      rd_ok_r <= (9'(in_chan.payload.read_x) < 9'(MAX_WIDTH)) &&
                 (9'(in_chan.payload.read_y) < 9'(MAX_HEIGHT));
      res_r   <= res_start;
    end

    if (state_r == rdmc_pkg::ST_RDCELL && rd_ok_r) begin
      res_r.visited_flag <= cell_rdata[rdmc_pkg::BIT_VIS];
      res_r.east_wall    <= cell_rdata[rdmc_pkg::BIT_RIGHT];
      res_r.south_wall   <= cell_rdata[rdmc_pkg::BIT_BOTTOM];
    end

    if (state_r == rdmc_pkg::ST_POP) begin
      cx_r         <= stk_rdata[XW-1:0];
      cy_r         <= stk_rdata[SW-1:XW];
      res_r.cell_x <= 6'(stk_rdata[XW-1:0]);
      res_r.cell_y <= 6'(stk_rdata[SW-1:XW]);
    end

    // Capture each probe in the cycle after its address went out.
    if (state_r == rdmc_pkg::ST_SCAN) begin
      case (k_r)
        3'd1:    cur_bits_r    <= cell_rdata;
        3'd2:    nbr_bits_r[0] <= cell_rdata;
        3'd3:    nbr_bits_r[1] <= cell_rdata;
        3'd4:    nbr_bits_r[2] <= cell_rdata;
        3'd5:    nbr_bits_r[3] <= cell_rdata;
        default: ;
      endcase
    end

    if (state_r == rdmc_pkg::ST_PICK) begin
      dir_r <= pick_dir;
      if (nbr_count != 3'd0) begin
        res_r.carved    <= 1'b1;
        res_r.direction <= pick_dir;
      end
    end

    if (state_r == rdmc_pkg::ST_DONE && out_free) begin
      out_data_r <= res_final;
    end
  end

  rdmc_ram #(
    .WIDTH(3),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .raddr(cell_raddr),
    .rdata(cell_rdata)
  );

  rdmc_ram #(
    .WIDTH(SW),
    .DEPTH(CELLS)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

endmodule

/* rtl/core/rdmc_checker.sv */
// Port-level checks of the maze carver, bound to the top level.
module rdmc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rdmc_pkg::out_item_t out_payload
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed or dropped");

  // The clearing pass after reset blocks requests.
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("request port ready during clearing pass");

  // One request in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // A carve pushes two cells, so the stack cannot be empty after it; its read flags stay clear.
  a_carve_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.carved |-> !out_payload.finished &&
      !out_payload.east_wall && !out_payload.south_wall && !out_payload.visited_flag)
    else $error("carve result flags inconsistent");

  // Direction is zero unless a wall was carved.
  a_dir_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.carved |-> out_payload.direction == rdmc_pkg::DIR_LEFT)
    else $error("direction set without a carve");

endmodule

bind random_dfs_maze_carver_top rdmc_checker u_rdmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_payload(out_chan.payload)
);

/* verif/rdmc_carve_checker.sv */
// Result checker for the maze carver: mirrors the carve walk and compares every result.
module rdmc_carve_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  rdmc_pkg::in_item_t              in_payload,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  rdmc_pkg::out_item_t             out_payload,
  input  logic                            cfg_we,
  input  logic [rdmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);

  localparam int CELLS = rdmc_pkg::MAX_WIDTH_DEF * rdmc_pkg::MAX_HEIGHT_DEF;

  logic [2:0]          grid [CELLS];
  logic [11:0]         trail [CELLS];  // coordinate stack, {y, x}
  int unsigned         trail_depth;
  logic [6:0]          cols_reg;
  logic [6:0]          rows_reg;
  rdmc_pkg::out_item_t cell_reports [$];

  function automatic int unsigned grid_at(input int unsigned x, input int unsigned y);
    return y * rdmc_pkg::MAX_WIDTH_DEF + x;
  endfunction

  function automatic int unsigned clamp_dim(input logic [6:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic void clear_grid();
    for (int i = 0; i < CELLS; i++) grid[i] = rdmc_pkg::CELL_WALLS;
    grid[0] = rdmc_pkg::CELL_ORIGIN;
    trail[0] = '0;
    trail_depth = 1;
  endfunction

  function automatic void push_trail(input int unsigned x, input int unsigned y);
    // drop a push beyond the stack size
    if (trail_depth < CELLS) begin
      trail[trail_depth] = {y[5:0], x[5:0]};
      trail_depth++;
    end
  endfunction

  function automatic rdmc_pkg::out_item_t predict_cell_report(input rdmc_pkg::in_item_t req);
    rdmc_pkg::out_item_t rpt;
    int unsigned cols, rows, x, y, here, count, pick;
    int unsigned nx [4];
    int unsigned ny [4];
    logic [1:0]  nd [4];
    rpt = '0;
    case (req.mode)
      rdmc_pkg::MODE_RESTART: clear_grid();
      rdmc_pkg::MODE_READ: begin
        here = grid_at(req.read_x, req.read_y);
        rpt.cell_x       = req.read_x;
        rpt.cell_y       = req.read_y;
        rpt.visited_flag = grid[here][rdmc_pkg::BIT_VIS];
        rpt.east_wall    = grid[here][rdmc_pkg::BIT_RIGHT];
        rpt.south_wall   = grid[here][rdmc_pkg::BIT_BOTTOM];
      end
      rdmc_pkg::MODE_STEP: if (trail_depth > 0) begin
        cols = clamp_dim(cols_reg, rdmc_pkg::MAX_WIDTH_DEF);
        rows = clamp_dim(rows_reg, rdmc_pkg::MAX_HEIGHT_DEF);
        trail_depth--;
        x = trail[trail_depth][5:0];
        y = trail[trail_depth][11:6];
        rpt.cell_x = x[5:0];
        rpt.cell_y = y[5:0];
        count = 0;
        // gather unvisited neighbors in scan order left, right, up, down
        if (x > 0 && !grid[grid_at(x - 1, y)][rdmc_pkg::BIT_VIS]) begin
          nx[count] = x - 1; ny[count] = y; nd[count] = rdmc_pkg::DIR_LEFT; count++;
        end
        if (x + 1 < cols && !grid[grid_at(x + 1, y)][rdmc_pkg::BIT_VIS]) begin
          nx[count] = x + 1; ny[count] = y; nd[count] = rdmc_pkg::DIR_RIGHT; count++;
        end
        if (y > 0 && !grid[grid_at(x, y - 1)][rdmc_pkg::BIT_VIS]) begin
          nx[count] = x; ny[count] = y - 1; nd[count] = rdmc_pkg::DIR_UP; count++;
        end
        if (y + 1 < rows && !grid[grid_at(x, y + 1)][rdmc_pkg::BIT_VIS]) begin
          nx[count] = x; ny[count] = y + 1; nd[count] = rdmc_pkg::DIR_DOWN; count++;
        end
        if (count > 0) begin
          pick = (int'(req.random_fraction) * count) >> 16;
          case (nd[pick])
            rdmc_pkg::DIR_RIGHT: grid[grid_at(x, y)] &= ~rdmc_pkg::MASK_RIGHT;
            rdmc_pkg::DIR_LEFT:  grid[grid_at(nx[pick], ny[pick])] &= ~rdmc_pkg::MASK_RIGHT;
            rdmc_pkg::DIR_DOWN:  grid[grid_at(x, y)] &= ~rdmc_pkg::MASK_BOTTOM;
            default:   grid[grid_at(nx[pick], ny[pick])] &= ~rdmc_pkg::MASK_BOTTOM;
          endcase
          grid[grid_at(nx[pick], ny[pick])] |= rdmc_pkg::MASK_VIS;
          push_trail(x, y);
          push_trail(nx[pick], ny[pick]);
          rpt.carved    = 1'b1;
          rpt.direction = nd[pick];
        end
      end
      default: ;
    endcase
    rpt.finished = (trail_depth == 0);
    return rpt;
  endfunction

  function automatic int field_diff(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    rdmc_pkg::out_item_t want;
    if (!rst_n) begin
      clear_grid();
      cols_reg = rdmc_pkg::CFG_SIZE_RST;
      rows_reg = rdmc_pkg::CFG_SIZE_RST;
      cell_reports.delete();
    end else begin
      // retire results before adding the request accepted at this edge
      if (out_valid && out_ready) begin
        if (cell_reports.size() == 0) begin
          $error("result with no request waiting");
          fail_count++;
        end else begin
          want = cell_reports.pop_front();
          fail_count += field_diff("cell_x", want.cell_x, out_payload.cell_x);
          fail_count += field_diff("cell_y", want.cell_y, out_payload.cell_y);
          fail_count += field_diff("carved", want.carved, out_payload.carved);
          fail_count += field_diff("direction", want.direction, out_payload.direction);
          fail_count += field_diff("east_wall", want.east_wall, out_payload.east_wall);
          fail_count += field_diff("south_wall", want.south_wall, out_payload.south_wall);
          fail_count += field_diff("visited_flag", want.visited_flag,
                                   out_payload.visited_flag);
          fail_count += field_diff("finished", want.finished, out_payload.finished);
        end
      end
      if (cfg_we) begin
        if (cfg_index == rdmc_pkg::CFG_WIDTH_IDX) cols_reg = cfg_wdata;
        else if (cfg_index == rdmc_pkg::CFG_HEIGHT_IDX) rows_reg = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        cell_reports = {cell_reports, predict_cell_report(in_payload)};
      end
    end
    pending <= cell_reports.size();
  end

endmodule

/* verif/tb_random_dfs_maze_carver_top.sv */
// Testbench top for the maze carver: request stimulus, result stalls, size writes, verdict.
module tb_random_dfs_maze_carver_top;

  // Mode 3 is not a real request; the block treats it as an idle step.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // A restart clears 4096 cells with no handshake in between, and a result may
  // additionally sit behind the long hold-off; allow several times that.
  localparam int WATCHDOG_LIMIT = 25000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 94;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [rdmc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rdmc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int          fail_count;
  int          pending;
  int          gap_pct;      // chance in percent that the sender idles a cycle
  int          stall_pct;    // chance in percent that the receiver stalls a cycle
  bit          hold_req;     // asks the receiver for one long hold-off
  int          quiet_cycles = 0;
  int unsigned cols_eff;     // grid size in use, for aiming reads
  int unsigned rows_eff;

  rdmc_chan_if #(.payload_t(rdmc_pkg::in_item_t))  in_if ();
  rdmc_chan_if #(.payload_t(rdmc_pkg::out_item_t)) out_if ();

  always #5 clk = ~clk;

  random_dfs_maze_carver_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rdmc_carve_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_payload  (in_if.payload),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_payload (out_if.payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  function automatic rdmc_pkg::in_item_t make_req(input logic [1:0] mode,
                                                  input logic [15:0] frac,
                                                  input logic [5:0] x, input logic [5:0] y);
    rdmc_pkg::in_item_t req;
    req.mode            = mode;
    req.random_fraction = frac;
    req.read_x          = x;
    req.read_y          = y;
    return req;
  endfunction

  // Mostly steps, so the walk gets deep; reads aim inside the grid in use
  // most of the time; restarts stay rare since each one clears the full store.
  function automatic rdmc_pkg::in_item_t random_req();
    rdmc_pkg::in_item_t req;
    int unsigned        roll;
    roll = $urandom_range(0, 99);
    req  = make_req(rdmc_pkg::MODE_STEP, 16'($urandom), 6'($urandom), 6'($urandom));
    if (roll >= 82 && roll < 95) begin
      req.mode = rdmc_pkg::MODE_READ;
      if ($urandom_range(0, 3) != 0) begin
        req.read_x = 6'($urandom_range(0, cols_eff - 1));
        req.read_y = 6'($urandom_range(0, rows_eff - 1));
      end
    end else if (roll >= 95 && roll < 98) begin
      req.mode = MODE_SPARE;
    end else if (roll >= 98) begin
      req.mode = rdmc_pkg::MODE_RESTART;
    end
    return req;
  endfunction

  // Small grids let the walk finish and exercise the empty stack; the rest
  // covers the clamped, mid-range and full sizes.
  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'd64;
      3:       return 7'($urandom_range(9, 63));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  // Offer one request, idling first at random; return at the accepting edge
  // with valid still high so back-to-back requests need no gap.
  task automatic send_req(input rdmc_pkg::in_item_t req);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  // The first edge lets the checker count the request accepted just now.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both size registers on back-to-back edges; the block is idle here.
  task automatic write_sizes(input logic [6:0] cols, input logic [6:0] rows);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rdmc_pkg::CFG_WIDTH_IDX;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= rdmc_pkg::CFG_HEIGHT_IDX;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cols_eff = (cols == 0) ? 1 :
               ((cols > rdmc_pkg::MAX_WIDTH_DEF) ? rdmc_pkg::MAX_WIDTH_DEF : cols);
    rows_eff = (rows == 0) ? 1 :
               ((rows > rdmc_pkg::MAX_HEIGHT_DEF) ? rdmc_pkg::MAX_HEIGHT_DEF : rows);
  endtask

  // Result side: random stalls per phase, plus one long hold-off on request.
  initial begin : result_drain
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLDOFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run if no request and no result moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    cfg_we        = 1'b0;
    cfg_index     = rdmc_pkg::CFG_WIDTH_IDX;
    cfg_wdata     = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    cols_eff      = rdmc_pkg::MAX_WIDTH_DEF;
    rows_eff      = rdmc_pkg::MAX_HEIGHT_DEF;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset sizes; the first request waits out the
    // clearing pass on ready.
    send_req(make_req(rdmc_pkg::MODE_READ, 16'h0000, 6'd0, 6'd0));     // origin after reset
    send_req(make_req(rdmc_pkg::MODE_READ, 16'hFFFF, 6'd63, 6'd63));   // far corner, untouched
    send_req(make_req(rdmc_pkg::MODE_STEP, 16'h0000, 6'd63, 6'd0));    // lowest pick: right
    send_req(make_req(rdmc_pkg::MODE_STEP, 16'hFFFF, 6'd0, 6'd63));    // highest pick: down
    send_req(make_req(MODE_SPARE, 16'hFFFF, 6'd63, 6'd63));            // unused mode
    send_req(make_req(rdmc_pkg::MODE_READ, 16'h0000, 6'd1, 6'd0));
    send_req(make_req(rdmc_pkg::MODE_READ, 16'h0000, 6'd1, 6'd1));
    send_req(make_req(rdmc_pkg::MODE_RESTART, 16'h5A5A, 6'd21, 6'd42));
    send_req(make_req(rdmc_pkg::MODE_READ, 16'h0000, 6'd1, 6'd0));     // walls back after restart

    // One-cell grid: the walk ends at once, then step on the empty stack.
    write_sizes(7'd1, 7'd1);
    send_req(make_req(rdmc_pkg::MODE_STEP, 16'h8000, 6'd0, 6'd0));
    send_req(make_req(rdmc_pkg::MODE_STEP, 16'h8000, 6'd0, 6'd0));
    send_req(make_req(MODE_SPARE, 16'h0000, 6'd0, 6'd0));
    send_req(make_req(rdmc_pkg::MODE_READ, 16'h0000, 6'd0, 6'd0));

    // Out-of-range sizes clamp to one column and the full height; carve down
    // a few rows, then widen the grid with cells still on the stack.
    write_sizes(7'd0, 7'd127);
    send_req(make_req(rdmc_pkg::MODE_RESTART, 16'h0000, 6'd0, 6'd0));
    repeat (3) send_req(make_req(rdmc_pkg::MODE_STEP, 16'h0000, 6'd0, 6'd0));
    write_sizes(7'd64, 7'd127);
    send_req(make_req(rdmc_pkg::MODE_STEP, 16'h0000, 6'd0, 6'd0));     // right out of column 0
    send_req(make_req(rdmc_pkg::MODE_STEP, 16'h8000, 6'd0, 6'd0));     // middle pick: up
    send_req(make_req(rdmc_pkg::MODE_STEP, 16'hFFFF, 6'd0, 6'd0));
    send_req(make_req(rdmc_pkg::MODE_READ, 16'h0000, 6'd0, 6'd3));

    // Random part: phases of different sizes and idle patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 71; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 71; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      write_sizes(pick_size(), pick_size());
      // skip the restart now and then so the new sizes apply mid-walk
      if ($urandom_range(0, 9) < 7) begin
        send_req(make_req(rdmc_pkg::MODE_RESTART, 16'($urandom), 6'($urandom),
                          6'($urandom)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold results off while requests keep coming, so the block backs up
        if (p == 6 && n == 10) hold_req = 1'b1;
        // pause the sender until every result is back
        if (p == 9 && n == 40) drain_results();
        send_req(random_req());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
